### rtl/dpf_pkg.sv
// dpf_pkg: shared widths, register codes and structs for the dual detector peak finder.
// No dependencies; imported by dpf_lane, dpf_merge and dual_detector_peak_finder.
package dpf_pkg;

	// signal index range; the index counter saturates at the last index
	localparam int MAX_SIGNAL_LENGTH = 1048576;
	localparam int POS_W             = $clog2(MAX_SIGNAL_LENGTH);
	localparam logic [POS_W-1:0] LAST_INDEX = POS_W'(MAX_SIGNAL_LENGTH - 1);

	// u16.16 statistic and window widths
	localparam int LEVEL_W = 32;
	localparam int WIN_W   = 12;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

	// masked-until holds a peak index plus a window
	localparam int MASK_W = ((POS_W > WIN_W) ? POS_W : WIN_W) + 1;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = LEVEL_W;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_HEIGHT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_SHORT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_LONG  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SHORT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LONG     = 3'd4;

	// stream payload widths
	localparam int S_DATA_W = 2 * LEVEL_W;
	localparam int M_DATA_W = ((POS_W + 7) / 8) * 8;

	// result queue
	localparam int MAX_PER_ITEM = 2;
	localparam int RES_DEPTH    = 8;
	localparam int RES_PTR_W    = $clog2(RES_DEPTH);
	localparam int RES_CNT_W    = RES_PTR_W + 1;

	// what one lane reports for one request
	typedef struct packed {
		logic             emit;
		logic [POS_W-1:0] pos;
		logic             mask;
		logic [MASK_W-1:0] mask_until;
	} lane_out_t;

	// one queued result
	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic             from_long;
		logic             last;
	} result_t;

endpackage

### rtl/dual_detector_peak_finder.sv
// dual_detector_peak_finder: top level; index counter, config registers, two lanes, merge.
// Depends on dpf_pkg, dpf_lane and dpf_merge.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  s_*     | in        | s_tvalid/s_tready  | tdata: stat_short, stat_long; tuser: start
//  m_*     | out       | m_tvalid/m_tready  | tdata: peak_position; tuser: from_long; tlast
//  cfg_*   | in        | cfg_wr_en          | cfg_index selects register, cfg_data value
//
// One request per cycle while s_tready is high. The short lane works in the accept cycle, the
// long lane in the cycle after (it takes the short lane's mask from a pipeline register), and a
// result is offered from the result queue, which it enters after the stage 1 register.
// s_tready needs free result-queue space for four results while a request is in the long
// lane, two otherwise; a stalled m_tready fills the eight-entry queue and then stalls input.
// Reset clears the index, both lanes and the queue, and loads the register defaults.
module dual_detector_peak_finder
	import dpf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_DATA_W-1:0]   s_tdata,   // [31:0] stat_short, [63:32] stat_long
	input  logic [0:0]            s_tuser,   // [0] start_of_signal
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_DATA_W-1:0]   m_tdata,   // [19:0] peak_position, [23:20] zero
	output logic [0:0]            m_tuser,   // [0] from_long
	output logic                  m_tlast,   // last_of_item
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [LEVEL_W-1:0] height_q;
	logic [LEVEL_W-1:0] thr_short_q;
	logic [LEVEL_W-1:0] thr_long_q;
	logic [WIN_W-1:0]   win_short_q;
	logic [WIN_W-1:0]   win_long_q;

	logic [POS_W-1:0]   next_idx_q;
	logic [POS_W-1:0]   cur_idx;
	logic               accept;
	logic               room;

	lane_out_t          short_res;
	lane_out_t          long_res;

	logic               v_s1;
	lane_out_t          short_res_s1;
	logic               start_s1;
	logic [POS_W-1:0]   idx_s1;
	logic [LEVEL_W-1:0] stat_long_s1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q    <= LEVEL_W'(26214);
			thr_short_q <= LEVEL_W'(262144);
			thr_long_q  <= LEVEL_W'(229376);
			win_short_q <= WIN_W'(3);
			win_long_q  <= WIN_W'(9);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_PEAK_HEIGHT:     height_q    <= cfg_data;
				REG_THRESHOLD_SHORT: thr_short_q <= cfg_data;
				REG_THRESHOLD_LONG:  thr_long_q  <= cfg_data;
				REG_WINDOW_SHORT:    win_short_q <= cfg_data[WIN_W-1:0];
				REG_WINDOW_LONG:     win_long_q  <= cfg_data[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign s_tready = room;
	assign accept   = s_tvalid & room;

	// sample index, restarted by start_of_signal, saturating at the last index
	assign cur_idx = s_tuser[0] ? '0 : next_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_idx_q <= '0;
		end else if (accept) begin
			if (cur_idx < LAST_INDEX) begin
				next_idx_q <= cur_idx + POS_W'(1);
			end else begin
				next_idx_q <= cur_idx;
			end
		end
	end

	// short lane, in the accept cycle
	dpf_lane u_lane_short (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (accept),
		.clear      (s_tuser[0]),
		.kill       (1'b0),
		.kill_until ('0),
		.idx        (cur_idx),
		.cur        (s_tdata[LEVEL_W-1:0]),
		.thr        (thr_short_q),
		.height     (height_q),
		.win        (win_short_q),
		.win_short  (win_short_q),
		.res        (short_res)
	);

	// stage 1 register between the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			short_res_s1 <= short_res;
			start_s1     <= s_tuser[0];
			idx_s1       <= cur_idx;
			stat_long_s1 <= s_tdata[S_DATA_W-1:LEVEL_W];
		end
	end

	// long lane, behind the stage 1 register, masked by the short lane's peak
	dpf_lane u_lane_long (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (v_s1),
		.clear      (start_s1),
		.kill       (short_res_s1.mask),
		.kill_until (short_res_s1.mask_until),
		.idx        (idx_s1),
		.cur        (stat_long_s1),
		.thr        (thr_long_q),
		.height     (height_q),
		.win        (win_long_q),
		.win_short  (win_short_q),
		.res        (long_res)
	);

	// ordering and result queue
	dpf_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (v_s1),
		.short_res (short_res_s1),
		.long_res  (long_res),
		.pending   (v_s1),
		.room      (room),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

### rtl/dpf_lane.sv
// dpf_lane: one peak detector (minimum search, peak follow, confirm, emit) with its state.
// Depends on dpf_pkg.
module dpf_lane
	import dpf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               clear,
	input  logic               kill,
	input  logic [MASK_W-1:0]  kill_until,
	input  logic [POS_W-1:0]   idx,
	input  logic [LEVEL_W-1:0] cur,
	input  logic [LEVEL_W-1:0] thr,
	input  logic [LEVEL_W-1:0] height,
	input  logic [WIN_W-1:0]   win,
	input  logic [WIN_W-1:0]   win_short,
	output lane_out_t          res
);

	logic [MASK_W-1:0]  until_q;
	logic               active_q;
	logic [POS_W-1:0]   pidx_q;
	logic [LEVEL_W-1:0] plev_q;
	logic               conf_q;

	logic [MASK_W-1:0]  eff_until;
	logic               eff_active;
	logic [POS_W-1:0]   eff_pidx;
	logic [LEVEL_W-1:0] eff_plev;
	logic               eff_conf;

	logic               nxt_active;
	logic [POS_W-1:0]   nxt_pidx;
	logic [LEVEL_W-1:0] nxt_plev;
	logic               nxt_conf;

	logic               skip;
	logic               rise;
	logic [LEVEL_W-1:0] lev1;
	logic [POS_W-1:0]   idx1;
	logic               over;
	logic               conf1;
	logic [POS_W-1:0]   lag;
	logic               far;

	// state seen by this request: an earlier lane's mask wins over a start clear
	always_comb begin
		if (kill) begin
			eff_until  = kill_until;
			eff_active = 1'b0;
			eff_pidx   = '0;
			eff_plev   = LEVEL_MAX;
			eff_conf   = 1'b0;
		end else if (clear) begin
			eff_until  = '0;
			eff_active = 1'b0;
			eff_pidx   = '0;
			eff_plev   = LEVEL_MAX;
			eff_conf   = 1'b0;
		end else begin
			eff_until  = until_q;
			eff_active = active_q;
			eff_pidx   = pidx_q;
			eff_plev   = plev_q;
			eff_conf   = conf_q;
		end
	end

	// peak follow and confirm terms
	assign skip  = eff_until >= MASK_W'(idx);
	assign rise  = cur > eff_plev;
	assign lev1  = rise ? cur : eff_plev;
	assign idx1  = rise ? idx : eff_pidx;
	assign over  = lev1 > thr;
	assign conf1 = eff_conf | (over & ((lev1 - cur) > height));
	assign lag   = idx - idx1;
	assign far   = MASK_W'(lag) > MASK_W'(win[WIN_W-1:1]);

	// next state and report
	always_comb begin
		nxt_active     = eff_active;
		nxt_pidx       = eff_pidx;
		nxt_plev       = eff_plev;
		nxt_conf       = eff_conf;
		res.emit       = 1'b0;
		res.pos        = idx1;
		res.mask       = 1'b0;
		res.mask_until = MASK_W'(idx1) + MASK_W'(win_short);
		if (!skip) begin
			if (!eff_active) begin
				if (cur < eff_plev) begin
					nxt_plev = cur;
				end else if ((cur - eff_plev) > height) begin
					nxt_plev   = cur;
					nxt_pidx   = idx;
					nxt_active = 1'b1;
				end
			end else begin
				nxt_plev = lev1;
				nxt_pidx = idx1;
				nxt_conf = conf1;
				res.mask = over;
				if (conf1 && far) begin
					res.emit   = 1'b1;
					nxt_active = 1'b0;
					nxt_pidx   = '0;
					nxt_plev   = cur;
					nxt_conf   = 1'b0;
				end
			end
		end
	end

	// detector state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			until_q  <= '0;
			active_q <= 1'b0;
			pidx_q   <= '0;
			plev_q   <= LEVEL_MAX;
			conf_q   <= 1'b0;
		end else if (step) begin
			until_q  <= eff_until;
			active_q <= nxt_active;
			pidx_q   <= nxt_pidx;
			plev_q   <= nxt_plev;
			conf_q   <= nxt_conf;
		end
	end

endmodule

### rtl/dpf_merge.sv
// dpf_merge: combines the two lanes' reports into ordered results and queues them.
// Depends on dpf_pkg.
module dpf_merge
	import dpf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid,
	input  lane_out_t           short_res,
	input  lane_out_t           long_res,
	input  logic                pending,
	output logic                room,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,   // [19:0] peak_position, rest zero
	output logic [0:0]          m_tuser,   // [0] from_long
	output logic                m_tlast    // last_of_item
);

	result_t              mem [RES_DEPTH];
	logic [RES_PTR_W-1:0] wr_ptr_q;
	logic [RES_PTR_W-1:0] rd_ptr_q;
	logic [RES_CNT_W-1:0] count_q;

	logic                 n0;
	logic                 n1;
	logic                 pop;
	result_t              ent_a;
	result_t              ent_b;
	result_t              head;
	logic [RES_CNT_W-1:0] wr_cnt;
	logic [RES_CNT_W-1:0] free;
	logic [RES_CNT_W-1:0] need;

	// short result first; the later of two carries last
	assign n0 = valid & short_res.emit;
	assign n1 = valid & long_res.emit;

	always_comb begin
		ent_b.pos       = long_res.pos;
		ent_b.from_long = 1'b1;
		ent_b.last      = 1'b1;
		if (n0) begin
			ent_a.pos       = short_res.pos;
			ent_a.from_long = 1'b0;
			ent_a.last      = ~n1;
		end else begin
			ent_a = ent_b;
		end
	end

	assign wr_cnt = RES_CNT_W'(n0) + RES_CNT_W'(n1);
	assign pop    = m_tvalid & m_tready;

	// room for the request in flight and one more
	assign free = RES_CNT_W'(RES_DEPTH) - count_q;
	assign need = pending ? RES_CNT_W'(2 * MAX_PER_ITEM) : RES_CNT_W'(MAX_PER_ITEM);
	assign room = free >= need;

	// queue storage
	always_ff @(posedge clk) begin
		if (n0 | n1) begin
			mem[wr_ptr_q] <= ent_a;
		end
		if (n0 & n1) begin
			mem[wr_ptr_q + RES_PTR_W'(1)] <= ent_b;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RES_PTR_W'(wr_cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + RES_PTR_W'(1);
			end
			count_q <= count_q + wr_cnt - RES_CNT_W'(pop);
		end
	end

	// head of queue drives the result stream
	assign head     = mem[rd_ptr_q];
	assign m_tvalid = count_q != '0;
	assign m_tdata  = M_DATA_W'(head.pos);
	assign m_tuser  = head.from_long;
	assign m_tlast  = head.last;

endmodule
